@@ rtl/sec_pkg.sv @@
// shared types, constants and pair conversion functions for the shift-jis / euc-jp converter
// no dependencies
package sec_pkg;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int QCw    = $clog2(QDepth + 1);

    localparam logic DirSjisToEuc = 1'b0;
    localparam logic DirEucToSjis = 1'b1;

    localparam logic [7:0] SpaceByte = 8'h20;
    localparam logic [7:0] HighBit   = 8'h80;
    localparam logic [7:0] LowMask   = 8'h7f;

    // one queued job: one or two result bytes from one input transaction
    typedef struct packed {
        logic       two;
        logic [7:0] b0;
        logic [7:0] b1;
        logic       eos;
    } t_job;

    // shift-jis pair to jis pair, 8-bit wrapping
    function automatic logic [15:0] sj_to_jis(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        begin
            if (hi <= 8'h9f) begin
                h = hi - 8'h70;
            end else begin
                h = hi - 8'hb0;
            end
            h = {h[6:0], 1'b0};
            if (lo >= 8'h9f) begin
                l = lo - 8'h7e;
            end else begin
                h = h - 8'h01;
                if (lo >= 8'h80) begin
                    l = lo - 8'h20;
                end else begin
                    l = lo - 8'h1f;
                end
            end
            return {h, l};
        end
    endfunction

    // jis pair (bit 7 clear) to shift-jis pair, 8-bit wrapping
    function automatic logic [15:0] jis_to_sj(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        begin
            if (hi[0]) begin
                l = lo + 8'h1f;
            end else begin
                l = lo + 8'h7d;
            end
            if (l >= 8'h7f) begin
                l = l + 8'h01;
            end
            if (hi >= 8'h5f) begin
                h = hi - 8'h5f;
                h = {1'b0, h[7:1]} + 8'he0;
            end else begin
                h = hi - 8'h21;
                h = {1'b0, h[7:1]} + 8'h81;
            end
            return {h, l};
        end
    endfunction

endpackage

@@ rtl/sec_front.sv @@
// front end: accepts input bytes, tracks the pending lead byte and builds result jobs
// depends on sec_pkg
module sec_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_direction,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_end_of_string,
    output logic          o_push,
    output sec_pkg::t_job o_job
);
    import sec_pkg::*;

    logic       r_pend_valid;
    logic [7:0] r_pend_byte;
    logic       n_pend_valid;
    logic [7:0] n_pend_byte;
    logic       job_valid;
    logic       is_lead;
    logic [15:0] sj_pair;
    logic [15:0] euc_pair;

    assign is_lead  = ((i_data_byte >= 8'h81) && (i_data_byte <= 8'h9f))
                    || (i_data_byte >= 8'he0);
    assign sj_pair  = sj_to_jis(r_pend_byte, i_data_byte);
    assign euc_pair = jis_to_sj(r_pend_byte & LowMask, i_data_byte & LowMask);

    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_byte  = r_pend_byte;
        job_valid    = 1'b0;
        o_job.two    = 1'b0;
        o_job.b0     = i_data_byte;
        o_job.b1     = i_data_byte;
        o_job.eos    = i_end_of_string;
        if (i_direction == DirSjisToEuc) begin
            if (r_pend_valid) begin
                n_pend_valid = 1'b0;
                job_valid    = 1'b1;
                o_job.two    = 1'b1;
                o_job.b0     = sj_pair[15:8] | HighBit;
                o_job.b1     = sj_pair[7:0] | HighBit;
            end else if (is_lead) begin
                if (i_end_of_string) begin
                    job_valid = 1'b1;
                    o_job.b0  = SpaceByte;
                end else begin
                    n_pend_valid = 1'b1;
                    n_pend_byte  = i_data_byte;
                end
            end else begin
                job_valid = 1'b1;
            end
        end else begin
            if (r_pend_valid) begin
                n_pend_valid = 1'b0;
                job_valid    = 1'b1;
                o_job.two    = 1'b1;
                if (i_data_byte[7]) begin
                    o_job.b0 = euc_pair[15:8];
                    o_job.b1 = euc_pair[7:0];
                end else begin
                    o_job.b0 = r_pend_byte;
                    o_job.b1 = i_data_byte;
                end
            end else if (i_data_byte[7] && !i_end_of_string) begin
                n_pend_valid = 1'b1;
                n_pend_byte  = i_data_byte;
            end else begin
                job_valid = 1'b1;
            end
        end
    end

    assign o_push = i_accept && job_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_byte  <= '0;
        end else if (i_accept) begin
            r_pend_valid <= n_pend_valid;
            r_pend_byte  <= n_pend_byte;
        end
    end

endmodule

@@ rtl/sec_queue.sv @@
// short job queue between front and back ends
// depends on sec_pkg
module sec_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sec_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output sec_pkg::t_job o_job
);
    import sec_pkg::*;

    t_job           r_mem [QDepth];
    logic [QAw-1:0] r_wptr;
    logic [QAw-1:0] r_rptr;
    logic [QCw-1:0] r_count;

    assign o_full  = (r_count == QCw'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/sec_back.sv @@
// back end: splits jobs into single bytes and drives the output register
// depends on sec_pkg
module sec_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  sec_pkg::t_job i_q_job,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_run_end,
    output logic          o_string_end
);
    import sec_pkg::*;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_run_end;
    logic       r_string_end;
    logic       r_hold_valid;
    logic [7:0] r_hold_byte;
    logic       r_hold_eos;

    logic       n_out_valid;
    logic [7:0] n_out_byte;
    logic       n_run_end;
    logic       n_string_end;
    logic       n_hold_valid;
    logic [7:0] n_hold_byte;
    logic       n_hold_eos;
    logic       out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_pop    = out_free && !r_hold_valid && i_q_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_byte   = r_out_byte;
        n_run_end    = r_run_end;
        n_string_end = r_string_end;
        n_hold_valid = r_hold_valid;
        n_hold_byte  = r_hold_byte;
        n_hold_eos   = r_hold_eos;
        if (out_free) begin
            if (r_hold_valid) begin
                // second byte of a pair
                n_out_valid  = 1'b1;
                n_out_byte   = r_hold_byte;
                n_run_end    = 1'b1;
                n_string_end = r_hold_eos;
                n_hold_valid = 1'b0;
            end else if (i_q_valid) begin
                n_out_valid  = 1'b1;
                n_out_byte   = i_q_job.b0;
                n_run_end    = !i_q_job.two;
                n_string_end = !i_q_job.two && i_q_job.eos;
                n_hold_valid = i_q_job.two;
                n_hold_byte  = i_q_job.b1;
                n_hold_eos   = i_q_job.eos;
            end else begin
                n_out_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_run_end    <= n_run_end;
        r_string_end <= n_string_end;
        r_hold_byte  <= n_hold_byte;
        r_hold_eos   <= n_hold_eos;
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_run_end    = r_run_end;
    assign o_string_end = r_string_end;

endmodule

@@ rtl/sjis_euc_stream_converter.sv @@
// shift-jis / euc-jp byte stream converter, top level
// depends on sec_pkg, sec_front, sec_queue, sec_back
//
// converts a byte stream between shift-jis and euc-jp; i_cfg_wdata written with
// i_cfg_we selects the direction (0: shift-jis to euc-jp, 1: euc-jp to shift-jis),
// and should only change while the block is idle. the input side takes one byte
// per cycle as long as the four-entry job queue has room; the output register
// sends one byte per cycle while i_ready is high. a lead byte produces nothing
// on its own and its trailing byte produces two, so mixed text runs at one
// input byte per cycle; every two-byte result follows a held byte that gave
// nothing, so the single output port keeps pace with the input. the first
// result passes through the job queue and the output register before it is
// presented. run_end marks the last byte from one input transaction, string_end
// that byte when the input carried end of string.
module sjis_euc_stream_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_string,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_string_end
);
    import sec_pkg::*;

    // direction register, reset to shift-jis to euc-jp
    logic r_direction;

    logic q_full;
    logic q_valid;
    logic q_pop;
    logic push;
    logic accept;
    t_job front_job;
    t_job q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= DirSjisToEuc;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_wdata;
        end
    end

    // front stalls only on a full queue
    assign o_ready = !q_full;
    assign accept  = i_valid && o_ready;

    sec_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_direction     (r_direction),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_string (i_end_of_string),
        .o_push          (push),
        .o_job           (front_job)
    );

    sec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    sec_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_run_end    (o_run_end),
        .o_string_end (o_string_end)
    );

endmodule

@@ rtl/sec_checker.sv @@
// port-level checks for the converter, attached by bind
// depends on sjis_euc_stream_converter port list
module sec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_data_byte,
    input logic       i_end_of_string,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_end,
    input logic       o_string_end
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_data_byte)
            && $stable(i_end_of_string))
        else $error("input changed while stalled");

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte)
            && $stable(o_run_end) && $stable(o_string_end))
        else $error("output changed while stalled");

    // string end only on the last byte of a run
    a_end_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_string_end |-> o_run_end)
        else $error("string_end without run_end");

    // second byte of a pair follows right after the first is taken
    a_pair_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_run_end |=> o_valid)
        else $error("gap inside a two-byte run");

    // nothing on the output right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind sjis_euc_stream_converter sec_checker u_sec_checker (.*);
